[design/rsie_pkg.sv]
// Shared types and encoding constants for the RV32I subset encoder.
package rsie_pkg;

  localparam int unsigned OUT_ADDR_BITS = 24;

  typedef enum logic [3:0] {
    ACT_ADD     = 4'd0,
    ACT_SUB     = 4'd1,
    ACT_XOR     = 4'd2,
    ACT_OR      = 4'd3,
    ACT_AND     = 4'd4,
    ACT_SLLI    = 4'd5,
    ACT_SRLI    = 4'd6,
    ACT_ADDI    = 4'd7,
    ACT_LW      = 4'd8,
    ACT_JALR    = 4'd9,
    ACT_SW      = 4'd10,
    ACT_BEQ     = 4'd11,
    ACT_BNE     = 4'd12,
    ACT_LUI     = 4'd13,
    ACT_JAL     = 4'd14,
    ACT_UNKNOWN = 4'd15
  } action_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_UNKNOWN  = 3'd1,
    ST_IMM_RANGE = 3'd2,
    ST_ODD_OFF  = 3'd3,
    ST_OFF_RANGE = 3'd4
  } status_t;

  localparam logic [6:0] OPC_OP     = 7'b0110011;
  localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_JALR   = 7'b1100111;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_LUI    = 7'b0110111;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;

  localparam logic [6:0] F7_BASE = 7'b0000000;
  localparam logic [6:0] F7_ALT  = 7'b0100000;

  localparam logic [2:0] F3_ADD = 3'd0;
  localparam logic [2:0] F3_SLL = 3'd1;
  localparam logic [2:0] F3_W   = 3'd2;
  localparam logic [2:0] F3_XOR = 3'd4;
  localparam logic [2:0] F3_SRL = 3'd5;
  localparam logic [2:0] F3_OR  = 3'd6;
  localparam logic [2:0] F3_AND = 3'd7;
  localparam logic [2:0] F3_BEQ = 3'd0;
  localparam logic [2:0] F3_BNE = 3'd1;

  typedef struct packed {
    logic [31:0]              word;
    status_t                  status;
    logic [OUT_ADDR_BITS-1:0] addr;
  } enc_res_t;

endpackage

[design/rsie_encode.sv]
// Combinational encoder: field checks and RV32I word assembly for one item.
module rsie_encode
  import rsie_pkg::*;
#(
  parameter int unsigned ADDR_BITS = 24
) (
  input  logic [3:0]              action,
  input  logic [4:0]              dest_reg,
  input  logic [4:0]              src1_reg,
  input  logic [4:0]              src2_reg,
  input  logic [31:0]             immediate,
  input  logic [23:0]             target_address,
  input  logic [ADDR_BITS-1:0]    here,
  output enc_res_t                res
);

  logic [ADDR_BITS-1:0]  tgt;
  logic signed [ADDR_BITS:0] diff;
  logic signed [32:0]    off;
  logic                  imm12_ok;
  logic                  shamt_ok;
  logic                  br_ok;
  logic                  jal_ok;
  logic [31:0]           word;
  status_t               status;

  if (ADDR_BITS >= OUT_ADDR_BITS) begin : g_wide
    assign tgt      = ADDR_BITS'(target_address);
    assign res.addr = here[OUT_ADDR_BITS-1:0];
  end else begin : g_narrow
    assign tgt      = target_address[ADDR_BITS-1:0];
    assign res.addr = OUT_ADDR_BITS'(here);
  end

  assign diff = signed'({1'b0, tgt}) - signed'({1'b0, here});
  assign off  = 33'(diff);

  assign imm12_ok = (&immediate[31:11]) || !(|immediate[31:11]);
  assign shamt_ok = !(|immediate[31:5]);
  assign br_ok    = (&off[32:12]) || !(|off[32:12]);
  assign jal_ok   = (&off[32:20]) || !(|off[32:20]);

  always_comb begin
    word   = '0;
    status = ST_OK;
    unique case (action_t'(action))
      ACT_ADD: word = {F7_BASE, src2_reg, src1_reg, F3_ADD, dest_reg, OPC_OP};
      ACT_SUB: word = {F7_ALT, src2_reg, src1_reg, F3_ADD, dest_reg, OPC_OP};
      ACT_XOR: word = {F7_BASE, src2_reg, src1_reg, F3_XOR, dest_reg, OPC_OP};
      ACT_OR:  word = {F7_BASE, src2_reg, src1_reg, F3_OR, dest_reg, OPC_OP};
      ACT_AND: word = {F7_BASE, src2_reg, src1_reg, F3_AND, dest_reg, OPC_OP};
      ACT_SLLI, ACT_SRLI: begin
        if (!shamt_ok) begin
          status = ST_IMM_RANGE;
        end else begin
          word = {F7_BASE, immediate[4:0], src1_reg,
                  (action_t'(action) == ACT_SLLI) ? F3_SLL : F3_SRL, dest_reg, OPC_OPIMM};
        end
      end
      ACT_ADDI: begin
        if (!imm12_ok) status = ST_IMM_RANGE;
        else word = {immediate[11:0], src1_reg, F3_ADD, dest_reg, OPC_OPIMM};
      end
      ACT_LW: begin
        if (!imm12_ok) status = ST_IMM_RANGE;
        else word = {immediate[11:0], src1_reg, F3_W, dest_reg, OPC_LOAD};
      end
      ACT_JALR: begin
        if (!imm12_ok) status = ST_IMM_RANGE;
        else word = {immediate[11:0], src1_reg, F3_ADD, dest_reg, OPC_JALR};
      end
      ACT_SW: begin
        if (!imm12_ok) status = ST_IMM_RANGE;
        else word = {immediate[11:5], src2_reg, src1_reg, F3_W, immediate[4:0], OPC_STORE};
      end
      ACT_BEQ, ACT_BNE: begin
        if (off[0]) begin
          status = ST_ODD_OFF;
        end else if (!br_ok) begin
          status = ST_OFF_RANGE;
        end else begin
          word = {off[12], off[10:5], src2_reg, src1_reg,
                  (action_t'(action) == ACT_BEQ) ? F3_BEQ : F3_BNE,
                  off[4:1], off[11], OPC_BRANCH};
        end
      end
      ACT_LUI: word = {immediate[19:0], dest_reg, OPC_LUI};
      ACT_JAL: begin
        if (off[0]) begin
          status = ST_ODD_OFF;
        end else if (!jal_ok) begin
          status = ST_OFF_RANGE;
        end else begin
          word = {off[20], off[10:1], off[11], off[19:12], dest_reg, OPC_JAL};
        end
      end
      ACT_UNKNOWN: status = ST_UNKNOWN;
      default:     status = ST_UNKNOWN;
    endcase
  end

  assign res.word   = word;
  assign res.status = status;

endmodule

[design/rsie_serialise.sv]
// Result register and byte serialiser for encoded words and error items.
module rsie_serialise
  import rsie_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  enc_res_t    res,
  output logic        can_load,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // out_byte[7:0], instr_address[31:8]
  output logic [2:0]  m_tuser,   // status[2:0]
  output logic        m_tlast
);

  logic     valid;
  logic     valid_next;
  logic [1:0] cnt;
  logic [1:0] cnt_next;
  enc_res_t held;
  logic     is_err;

  assign is_err   = (held.status != ST_OK);
  assign m_tvalid = valid;
  assign m_tlast  = is_err || (cnt == 2'd3);
  assign m_tdata  = {held.addr, held.word[8*cnt +: 8]};
  assign m_tuser  = held.status;
  assign can_load = !valid || (m_tready && m_tlast);

  always_comb begin
    valid_next = valid;
    cnt_next   = cnt;
    if (load) begin
      valid_next = 1'b1;
      cnt_next   = 2'd0;
    end else if (valid && m_tready) begin
      if (m_tlast) valid_next = 1'b0;
      cnt_next = cnt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      cnt   <= 2'd0;
    end else begin
      valid <= valid_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) held <= res;
  end

  a_err_single: assert property (@(posedge clk) disable iff (rst)
    valid && is_err |-> cnt == 2'd0)
    else $error("error item not on first beat");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> !valid || (m_tready && m_tlast))
    else $error("result register overwritten");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !m_tready |=> valid && $stable(cnt))
    else $error("byte counter moved while stalled");

endmodule

[design/rv32i_subset_instruction_encoder.sv]
// Top level: input register, address counter, encoder and byte serialiser.
// Each item is one pre-tokenised RV32I instruction; it leaves as four bytes, least
// significant first, with tlast on the fourth, or as a single error item with tlast set
// and the status code in tuser. The byte output port sets the sustained rate: four bytes
// per instruction, or one per cycle for items that fail a check, while m_tready is high.
// With the output idle, an item passes the input and result registers before its first
// byte is offered. A new item is taken while the previous word is still being sent.
// The address starts at 0 after reset and steps by 4 per item, wrapping at 2**ADDR_BITS.
module rv32i_subset_instruction_encoder
  import rsie_pkg::*;
#(
  parameter int unsigned ADDR_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // action[3:0], dest_reg[8:4], src1_reg[13:9], src2_reg[18:14],
  // immediate[50:19], target_address[74:51], zero[79:75]
  input  logic [79:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // out_byte[7:0], instr_address[31:8]
  output logic [2:0]  m_tuser,   // status[2:0]
  output logic        m_tlast
);

  logic [ADDR_BITS-1:0] current_address;
  logic                 valid;
  logic [74:0]          item;
  logic [ADDR_BITS-1:0] here;
  logic                 can_load;
  logic                 load;
  logic                 take;
  enc_res_t             res;

  assign load     = valid && can_load;
  assign s_tready = !valid || can_load;
  assign take     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid           <= 1'b0;
      current_address <= '0;
    end else begin
      if (take) begin
        valid           <= 1'b1;
        current_address <= current_address + ADDR_BITS'(4);
      end else if (load) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item <= s_tdata[74:0];
      here <= current_address;
    end
  end

  rsie_encode #(
    .ADDR_BITS(ADDR_BITS)
  ) u_encode (
    .action        (item[3:0]),
    .dest_reg      (item[8:4]),
    .src1_reg      (item[13:9]),
    .src2_reg      (item[18:14]),
    .immediate     (item[50:19]),
    .target_address(item[74:51]),
    .here          (here),
    .res           (res)
  );

  rsie_serialise u_serialise (
    .clk     (clk),
    .rst     (rst),
    .load    (load),
    .res     (res),
    .can_load(can_load),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  a_addr_step: assert property (@(posedge clk) disable iff (rst)
    take |=> current_address == $past(current_address) + ADDR_BITS'(4))
    else $error("address did not advance by four");

  a_addr_still: assert property (@(posedge clk) disable iff (rst)
    !take |=> $stable(current_address))
    else $error("address moved without an item");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !load |=> valid && $stable(item))
    else $error("input register lost an item");

endmodule
